@@ rtl/gbs_pkg.sv @@
// Shared types and constants for the greedy box suppression block.
// Used by the overlap unit and the top level; no dependencies.
package gbs_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW  = 15;
  localparam int unsigned AreaW  = 2 * SizeW;
  localparam int unsigned ThrW   = 9;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned UnionW = AreaW + 1;
  localparam int unsigned LhsW   = AreaW + 8;
  localparam int unsigned RhsW   = ThrW + UnionW;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(128);

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic        [SizeW-1:0]  width;
    logic        [SizeW-1:0]  height;
  } box_t;

  typedef struct packed {
    box_t             box;
    logic [AreaW-1:0] area;
  } kept_entry_t;

  // Result of one overlap test, handed back to the sequencer
  typedef struct packed {
    logic valid;
    logic suppress;
  } cmp_res_t;

endpackage

@@ rtl/gbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module gbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/gbs_overlap_unit.sv @@
// Pipelined overlap test: intersection, union and the Q8 ratio compare of one
// incoming box against one stored box per cycle. Depends on gbs_pkg.
module gbs_overlap_unit import gbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              flush_i,
  input  box_t              cur_box_i,
  input  logic [AreaW-1:0]  cur_area_i,
  input  kept_entry_t       entry_i,
  input  logic [ThrW-1:0]   thr_i,
  output cmp_res_t          res_o
);

  logic signed [CoordW+1:0] cur_r, ent_r, min_r, max_l;
  logic signed [CoordW+1:0] cur_b, ent_b, min_b, max_t;
  logic signed [CoordW+1:0] ow, oh;

  logic                 s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [SizeW-1:0]     ow_q, oh_q;
  logic [AreaW-1:0]     s1_area_q, s2_area_q;
  logic [AreaW-1:0]     inter_q;
  logic [AreaW-1:0]     s3_inter_q;
  logic [UnionW-1:0]    union_q;
  logic [LhsW-1:0]      lhs_q;
  logic [RhsW-1:0]      rhs_q;

  // Overlap extent on each axis
  always_comb begin
    cur_r = 18'(cur_box_i.left) + $signed({3'b000, cur_box_i.width});
    ent_r = 18'(entry_i.box.left) + $signed({3'b000, entry_i.box.width});
    min_r = (cur_r < ent_r) ? cur_r : ent_r;
    max_l = (cur_box_i.left > entry_i.box.left) ? 18'(cur_box_i.left)
                                                 : 18'(entry_i.box.left);
    ow    = min_r - max_l;
    cur_b = 18'(cur_box_i.top) + $signed({3'b000, cur_box_i.height});
    ent_b = 18'(entry_i.box.top) + $signed({3'b000, entry_i.box.height});
    min_b = (cur_b < ent_b) ? cur_b : ent_b;
    max_t = (cur_box_i.top > entry_i.box.top) ? 18'(cur_box_i.top)
                                               : 18'(entry_i.box.top);
    oh    = min_b - max_t;
  end

  // Stage valids, dropped on flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (flush_i) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // Datapath: clamp extents, multiply, form union, scale by threshold
  always_ff @(posedge clk_i) begin
    // an empty axis makes the whole intersection empty
    ow_q       <= (ow > 0 && oh > 0) ? ow[SizeW-1:0] : '0;
    oh_q       <= (ow > 0 && oh > 0) ? oh[SizeW-1:0] : '0;
    s1_area_q  <= entry_i.area;
    inter_q    <= ow_q * oh_q;
    s2_area_q  <= s1_area_q;
    union_q    <= UnionW'(cur_area_i) + UnionW'(s2_area_q) - UnionW'(inter_q);
    s3_inter_q <= inter_q;
    rhs_q      <= thr_i * union_q;
    lhs_q      <= {s3_inter_q, 8'h00};
  end

  assign res_o.valid    = s4_valid_q;
  assign res_o.suppress = RhsW'(lhs_q) > rhs_q;

endmodule

@@ rtl/greedy_box_suppression_top.sv @@
// Greedy box suppression: each box is tested against the boxes kept so far.
// A box's result follows a scan over the N boxes kept in the set so far (no scan when
// none is kept), and the scan ends early when a suppressing box is found;
// one stored box enters the overlap pipeline per cycle from the kept-box memory.
// A new box is accepted only after the previous result is loaded; a stalled result delays
// the next accept. Reset clears the counters and sets the threshold to 128.
module greedy_box_suppression_top import gbs_pkg::*; #(
  parameter int unsigned MAX_KEPT  = 64,
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_wr_en_i,
  input  logic [ThrW-1:0]          cfg_wr_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] box_left_i,
  input  logic signed [CoordW-1:0] box_top_i,
  input  logic [SizeW-1:0]         box_width_i,
  input  logic [SizeW-1:0]         box_height_i,
  input  logic                     final_box_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     kept_o,
  output logic [IdxW-1:0]          box_index_o,
  output logic                     store_overflow_o,
  output logic                     set_done_o
);

  localparam int unsigned KcW   = $clog2(MAX_KEPT + 1);
  localparam int unsigned AddrW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam logic [KcW-1:0]  MaxKeptC = KcW'(MAX_KEPT);
  localparam logic [IdxW-1:0] IdxCap   =
    IdxW'((MAX_BOXES - 1 < 1023) ? MAX_BOXES - 1 : 1023);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e            state_q, state_d;
  logic [ThrW-1:0]   thr_q;
  logic [KcW-1:0]    kept_count_q;
  logic [IdxW-1:0]   item_count_q;
  logic [KcW-1:0]    issue_q;
  logic [KcW-1:0]    res_cnt_q;
  logic              rvalid_q;
  logic              suppressed_q;
  logic              final_q;
  box_t              cur_box_q;
  logic [AreaW-1:0]  cur_area_q;
  logic              out_valid_q;
  logic              kept_q, overflow_q, set_done_q;
  logic [IdxW-1:0]   index_q;

  logic              in_acc;
  logic              rd_en;
  logic              hit;
  logic              last_res;
  logic              load_out;
  logic              keep;
  logic              room;
  kept_entry_t       rd_entry;
  kept_entry_t       wr_entry;
  cmp_res_t          cmp_res;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_en      = (state_q == StScan) && (issue_q < kept_count_q) && !hit;
  assign hit        = (state_q == StScan) && cmp_res.valid && cmp_res.suppress;
  assign last_res   = cmp_res.valid && (KcW'(res_cnt_q + 1'b1) == kept_count_q);
  assign load_out   = (state_q == StFinish) && (!out_valid_q || !out_stall_i);
  assign keep       = !suppressed_q;
  assign room       = kept_count_q < MaxKeptC;

  assign wr_entry.box  = cur_box_q;
  assign wr_entry.area = cur_area_q;

  // Kept-box store
  gbs_ram #(
    .Width ($bits(kept_entry_t)),
    .Depth (MAX_KEPT)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (load_out && keep && room),
    .waddr_i (kept_count_q[AddrW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (issue_q[AddrW-1:0]),
    .rdata_o (rd_entry)
  );

  // Overlap test pipeline
  gbs_overlap_unit u_overlap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rvalid_q),
    .flush_i    (hit),
    .cur_box_i  (cur_box_q),
    .cur_area_i (cur_area_q),
    .entry_i    (rd_entry),
    .thr_i      (thr_q),
    .res_o      (cmp_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = (kept_count_q == '0) ? StFinish : StScan;
        end
      end
      StScan: begin
        if (hit || last_res) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      thr_q        <= ThrReset;
      kept_count_q <= '0;
      item_count_q <= '0;
      issue_q      <= '0;
      res_cnt_q    <= '0;
      rvalid_q     <= 1'b0;
      suppressed_q <= 1'b0;
      final_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      kept_q       <= 1'b0;
      overflow_q   <= 1'b0;
      set_done_q   <= 1'b0;
      index_q      <= '0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rd_en;
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
      // start a new scan
      if (in_acc) begin
        issue_q      <= '0;
        res_cnt_q    <= '0;
        suppressed_q <= 1'b0;
        final_q      <= final_box_i;
      end
      if (rd_en) begin
        issue_q <= KcW'(issue_q + 1'b1);
      end
      if (state_q == StScan && cmp_res.valid) begin
        res_cnt_q <= KcW'(res_cnt_q + 1'b1);
      end
      if (hit) begin
        suppressed_q <= 1'b1;
      end
      // load result, or drop it once taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // update the result fields and the store bookkeeping
      if (load_out) begin
        kept_q      <= keep && room;
        overflow_q  <= keep && !room;
        set_done_q  <= final_q;
        index_q     <= item_count_q;
        if (final_q) begin
          kept_count_q <= '0;
          item_count_q <= '0;
        end else begin
          if (keep && room) begin
            kept_count_q <= KcW'(kept_count_q + 1'b1);
          end
          if (item_count_q < IdxCap) begin
            item_count_q <= IdxW'(item_count_q + 1'b1);
          end
        end
      end
    end
  end

  // Hold the incoming box and its area
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_box_q.left   <= box_left_i;
      cur_box_q.top    <= box_top_i;
      cur_box_q.width  <= box_width_i;
      cur_box_q.height <= box_height_i;
      cur_area_q       <= box_width_i * box_height_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kept_o           = kept_q;
  assign box_index_o      = index_q;
  assign store_overflow_o = overflow_q;
  assign set_done_o       = set_done_q;

endmodule
